### hw/rtl/mbrr_pkg.sv
// ----------------------------------------------------------------------------
// mbrr_pkg
// Shared types and constants of the Modbus RTU response receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrr_pkg;

  // request kinds on the input channel
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_IDLE = 2'd1;
  localparam logic [1:0] REQ_SENT = 2'd2;

  // function codes and masks
  localparam logic [7:0] FUNC_READ_HOLD    = 8'h03;
  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FUNC_EXC_MASK     = 8'h80;

  // modbus crc-16
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // frame layout
  localparam int MIN_FRAME     = 4;
  localparam int WR_SINGLE_LEN = 8;
  localparam int RD_HDR_LEN    = 5;
  localparam int ADDR_CODE     = 1;
  localparam int ADDR_COUNT    = 2;
  localparam int ADDR_DATA     = 3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_register;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        frame_error;
    logic        ready_flag;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_FUNC,
    ST_COUNT,
    ST_HI,
    ST_LO,
    ST_EMIT,
    ST_STATUS
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/mbrr_crc_serial.sv
// ----------------------------------------------------------------------------
// mbrr_crc_serial
// Bit-serial Modbus CRC-16 accumulator, one bit of a byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrr_crc_serial
  import mbrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        clear,
  input  wire logic [7:0]  byte_in,
  output logic             busy,
  output logic [15:0]      crc
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        fb;

  // one lfsr step per cycle, byte bits taken lsb first
  always_comb begin
    crc_nxt     = crc_r;
    sh_nxt      = sh_r;
    bit_cnt_nxt = bit_cnt_r;
    busy_nxt    = busy_r;
    fb          = crc_r[0] ^ sh_r[0];
    if (clear) begin
      crc_nxt = CRC_INIT;
    end else if (start) begin
      sh_nxt      = byte_in;
      bit_cnt_nxt = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      crc_nxt     = (crc_r >> 1) ^ (fb ? CRC_POLY : 16'h0000);
      sh_nxt      = sh_r >> 1;
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      if (bit_cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_INIT;
      busy_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      crc_r     <= crc_nxt;
      busy_r    <= busy_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  // data shift register
  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign busy = busy_r;
  assign crc  = crc_r;

  busy_runs_eight: assert property (@(posedge clk) disable iff (!rst_n)
    start && !clear |=> busy ##7 busy ##1 !busy)
    else $error("crc unit did not run eight bit steps");

  clear_restores_init: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> crc == CRC_INIT)
    else $error("crc not restored after clear");

  idle_holds_crc: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start && !clear |=> $stable(crc))
    else $error("crc changed while idle");

endmodule

`default_nettype wire

### hw/rtl/modbus_rtu_response_receiver_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_receiver_unit
// Master-side Modbus RTU response receiver with frame checks.
// ----------------------------------------------------------------------------
// A received byte is accepted and handed to the bit-serial CRC unit, which
// steps one bit per cycle while further requests stall. An end-of-frame request
// goes straight to the status result when the length or CRC check fails; else
// the frame store, with its single read port, is read in turn for the code byte,
// the count byte, then the high and low data bytes of each emitted register. A
// request-sent event goes straight to the status result. Output stalls hold the
// emit and status states. The output register lets a request be accepted while a
// result still waits. No clearing pass is needed after reset.
`default_nettype none

module modbus_rtu_response_receiver_unit
  import mbrr_pkg::*;
#(
  parameter int NUM_REGS  = 8,
  parameter int MAX_FRAME = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  localparam int STORE_DEPTH = ADDR_DATA + 2 * NUM_REGS;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(MAX_FRAME + 2);
  localparam int IW = $clog2(NUM_REGS + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     nr_r, nr_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic              error_r, error_nxt;
  logic              ready_r, ready_nxt;
  logic              frame_end_r, frame_end_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              out_load;
  out_item_t         out_load_data;
  logic              out_free;
  logic              in_accept;
  logic              crc_start, crc_clear, crc_busy;
  logic [15:0]       crc_val;
  logic [7:0]        store_mem [STORE_DEPTH];
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data_r;
  logic              wr_en;
  logic [AW-1:0]     data_addr;
  logic [6:0]        nr_field;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign wr_en     = in_accept && (in_data.req_type == REQ_BYTE) &&
                     (int'(cnt_r) < STORE_DEPTH);
  assign data_addr = AW'({idx_r, 1'b0}) + AW'(ADDR_DATA);
  assign nr_field  = rd_data_r[7:1];

  // crc unit
  mbrr_crc_serial u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (crc_start),
    .clear   (crc_clear),
    .byte_in (in_data.rx_byte),
    .busy    (crc_busy),
    .crc     (crc_val)
  );

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[AW'(cnt_r)] <= in_data.rx_byte;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    nr_nxt        = nr_r;
    hi_nxt        = hi_r;
    error_nxt     = error_r;
    ready_nxt     = ready_r;
    frame_end_nxt = frame_end_r;
    in_stall      = (state_r != ST_IDLE) || crc_busy;
    rd_addr       = AW'(ADDR_CODE);
    crc_start     = 1'b0;
    crc_clear     = 1'b0;
    out_load      = 1'b0;
    out_load_data = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data.req_type)
            REQ_BYTE: begin
              crc_start = 1'b1;
              if (int'(cnt_r) < MAX_FRAME + 1) begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            REQ_IDLE: begin
              frame_end_nxt = 1'b1;
              if (int'(cnt_r) < MIN_FRAME || int'(cnt_r) > MAX_FRAME ||
                  crc_val != 16'h0000) begin
                error_nxt = 1'b1;
                ready_nxt = 1'b1;
                state_nxt = ST_STATUS;
              end else begin
                state_nxt = ST_CODE;
              end
            end
            REQ_SENT: begin
              frame_end_nxt = 1'b0;
              ready_nxt     = 1'b0;
              state_nxt     = ST_STATUS;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CODE: begin
        rd_addr   = AW'(ADDR_CODE);
        state_nxt = ST_FUNC;
      end
      ST_FUNC: begin
        // function code is on the read port
        rd_addr = AW'(ADDR_COUNT);
        if ((rd_data_r & FUNC_EXC_MASK) != 8'h00) begin
          error_nxt = 1'b1;
          ready_nxt = 1'b1;
          state_nxt = ST_STATUS;
        end else begin
          error_nxt = 1'b0;
          priority if (rd_data_r == FUNC_READ_HOLD) begin
            state_nxt = ST_COUNT;
          end else if (rd_data_r == FUNC_WRITE_SINGLE) begin
            if (int'(cnt_r) != WR_SINGLE_LEN) begin
              error_nxt = 1'b1;
            end
            ready_nxt = 1'b1;
            state_nxt = ST_STATUS;
          end else begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_COUNT: begin
        // byte count field is on the read port
        rd_addr = AW'(ADDR_DATA);
        idx_nxt = '0;
        if (int'(nr_field) > NUM_REGS ||
            int'(cnt_r) != RD_HDR_LEN + int'(rd_data_r)) begin
          error_nxt = 1'b1;
          ready_nxt = 1'b1;
          state_nxt = ST_STATUS;
        end else if (nr_field == 7'd0) begin
          ready_nxt = 1'b1;
          state_nxt = ST_STATUS;
        end else begin
          nr_nxt    = IW'(nr_field);
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        rd_addr   = data_addr;
        state_nxt = ST_LO;
      end
      ST_LO: begin
        rd_addr   = data_addr + AW'(1);
        hi_nxt    = rd_data_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        rd_addr = data_addr + AW'(1);
        if (out_free) begin
          out_load                  = 1'b1;
          out_load_data.is_register = 1'b1;
          out_load_data.reg_index   = 3'(idx_r);
          out_load_data.reg_value   = {hi_r, rd_data_r};
          out_load_data.ready_flag  = 1'b1;
          idx_nxt                   = idx_r + IW'(1);
          if (idx_r + IW'(1) == nr_r) begin
            ready_nxt = 1'b1;
            state_nxt = ST_STATUS;
          end else begin
            state_nxt = ST_HI;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_load                  = 1'b1;
          out_load_data.frame_error = error_r;
          out_load_data.ready_flag  = ready_r;
          out_load_data.last        = 1'b1;
          state_nxt                 = ST_IDLE;
          if (frame_end_r) begin
            crc_clear = 1'b1;
            cnt_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      error_r     <= 1'b0;
      ready_r     <= 1'b1;
      frame_end_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      error_r     <= error_nxt;
      ready_r     <= ready_nxt;
      frame_end_r <= frame_end_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    nr_r  <= nr_nxt;
    hi_r  <= hi_nxt;
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  byte_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.req_type == REQ_BYTE |=> in_stall && crc_busy)
    else $error("byte request did not start the crc unit");

  status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_register |-> out_data.last)
    else $error("status result without last mark");

  register_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_register |->
      !out_data.frame_error && out_data.ready_flag && !out_data.last)
    else $error("register result with bad flags");

  count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_FRAME + 1)
    else $error("byte count beyond saturation");

  no_load_over_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !out_load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### bench/modbus_rtu_response_receiver_unit_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_receiver_unit_test
// Self-checking bench for the Modbus RTU response receiver. Slave response
// frames with real CRCs are built and sent as byte requests followed by an
// end-of-frame request. A cycle-free model of the receiver predicts every
// register update and status result, and the monitor compares each one field
// by field. Idle and stall pressure on both channels changes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrr_pkg::*;

  localparam int REG_COUNT   = 8;
  localparam int FRAME_MAX   = 256;
  localparam int STORE_DEPTH = 3 + 2 * REG_COUNT;
  localparam int PHASE_ITEMS = 10;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [7:0] FUNC_OTHER = 8'h10;

  // sender idle and receiver stall odds in percent, one entry per phase
  localparam int SEND_IDLE_PCT [4] = '{0, 59, 0, 10};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 59, 10};

  typedef struct {
    in_item_t item;
    int       phase;
    bit       drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // request stream and expected results
  pending_t  pending_requests[$];
  out_item_t expected_results[$];
  logic [7:0] frame_body[$];

  // receiver model state
  logic [15:0] rx_crc;
  logic [8:0]  rx_count;
  logic [7:0]  rx_store[STORE_DEPTH];
  logic [15:0] holding_regs[REG_COUNT];
  logic        ready_bit;
  logic        error_bit;

  int  active_phase = 0;
  int  build_phase = 0;
  bit  build_drain = 1'b0;
  int  counted_items = 0;
  int  requests_accepted = 0;
  int  results_checked = 0;
  int  register_results = 0;
  int  frames_sent = 0;
  int  error_count = 0;

  modbus_rtu_response_receiver_unit #(
    .NUM_REGS (REG_COUNT),
    .MAX_FRAME(FRAME_MAX)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  always #5 clk = ~clk;

  // modbus crc-16, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_result(logic isreg, logic [2:0] idx, logic [15:0] val,
                                      logic err, logic rdy, logic fin);
    out_item_t r;
    r = '0;
    r.is_register = isreg;
    r.reg_index   = idx;
    r.reg_value   = val;
    r.frame_error = err;
    r.ready_flag  = rdy;
    r.last        = fin;
    expected_results.push_back(r);
  endfunction

  // end of frame: length, crc, exception, then function specific checks
  function automatic void judge_frame();
    logic       bad;
    logic [7:0] code;
    int         nb;
    int         nr;
    logic [15:0] v;
    code = rx_store[ADDR_CODE];
    nb = rx_store[ADDR_COUNT];
    nr = nb >> 1;
    bad = (rx_count < MIN_FRAME) || (rx_count > FRAME_MAX) || (rx_crc != 16'h0000);
    if (!bad) bad = (code & FUNC_EXC_MASK) != 8'h00;
    if (!bad && code == FUNC_READ_HOLD) begin
      bad = (nr > REG_COUNT) || (rx_count != RD_HDR_LEN + nb);
    end else if (!bad && code == FUNC_WRITE_SINGLE) begin
      bad = rx_count != WR_SINGLE_LEN;
    end
    if (bad) begin
      error_bit = 1'b1;
      ready_bit = 1'b1;
      push_result(1'b0, 3'd0, 16'h0000, 1'b1, 1'b1, 1'b1);
    end else begin
      error_bit = 1'b0;
      if (code == FUNC_READ_HOLD) begin
        for (int i = 0; i < nr; i++) begin
          v = {rx_store[ADDR_DATA + 2 * i], rx_store[ADDR_DATA + 2 * i + 1]};
          holding_regs[i] = v;
          push_result(1'b1, 3'(i), v, 1'b0, 1'b1, 1'b0);
        end
        ready_bit = 1'b1;
      end else if (code == FUNC_WRITE_SINGLE) begin
        ready_bit = 1'b1;
      end
      push_result(1'b0, 3'd0, 16'h0000, error_bit, ready_bit, 1'b1);
    end
  endfunction

  // model step for one accepted request
  function automatic void predict_response(in_item_t req);
    case (req.req_type)
      REQ_BYTE: begin
        rx_crc = crc16_byte(rx_crc, req.rx_byte);
        if (rx_count < STORE_DEPTH) rx_store[rx_count] = req.rx_byte;
        if (rx_count < FRAME_MAX + 1) rx_count = rx_count + 9'd1;
      end
      REQ_IDLE: begin
        judge_frame();
        rx_crc = CRC_INIT;
        rx_count = '0;
      end
      REQ_SENT: begin
        ready_bit = 1'b0;
        push_result(1'b0, 3'd0, 16'h0000, error_bit, 1'b0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // driver: presents queued requests, models each one on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_response(in_data);
        requests_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 &&
            (!pending_requests[0].drain || expected_results.size() == 0) &&
            $urandom_range(99) >= SEND_IDLE_PCT[pending_requests[0].phase]) begin
          in_data      <= pending_requests[0].item;
          active_phase <= pending_requests[0].phase;
          in_valid     <= 1'b1;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%0h", out_data));
        end else begin
          want = expected_results.pop_front();
          check_field("is_register", 16'(out_data.is_register), 16'(want.is_register));
          check_field("reg_index", 16'(out_data.reg_index), 16'(want.reg_index));
          check_field("reg_value", out_data.reg_value, want.reg_value);
          check_field("frame_error", 16'(out_data.frame_error), 16'(want.frame_error));
          check_field("ready_flag", 16'(out_data.ready_flag), 16'(want.ready_flag));
          check_field("last", 16'(out_data.last), 16'(want.last));
          results_checked++;
          if (want.is_register) register_results++;
        end
      end
      out_stall <= ($urandom_range(99) < RECV_STALL_PCT[active_phase]);
    end
  end

  // stimulus helpers
  task automatic add_request(logic [1:0] kind, logic [7:0] b);
    pending_t p;
    p.item.req_type = kind;
    p.item.rx_byte  = b;
    p.phase = build_phase;
    p.drain = build_drain;
    build_drain = 1'b0;
    pending_requests.push_back(p);
    if (kind != REQ_UNUSED) counted_items++;
  endtask

  task automatic add_random_bytes(int n);
    for (int i = 0; i < n; i++) frame_body.push_back(8'($urandom));
  endtask

  // body bytes, crc low then high, then end of frame
  task automatic send_frame(bit corrupt);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (frame_body[i]) crc = crc16_byte(crc, frame_body[i]);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(15));
    foreach (frame_body[i]) add_request(REQ_BYTE, frame_body[i]);
    add_request(REQ_BYTE, crc[7:0]);
    add_request(REQ_BYTE, crc[15:8]);
    add_request(REQ_IDLE, 8'($urandom));
    frames_sent++;
  endtask

  // long frame with a good crc and a plain function code
  task automatic send_long_frame(int total_len);
    frame_body.delete();
    frame_body.push_back(8'($urandom));
    frame_body.push_back(FUNC_OTHER);
    add_random_bytes(total_len - 4);
    send_frame(1'b0);
  endtask

  // one response, mostly well formed, sometimes broken
  task automatic random_frame();
    int kind;
    int nb;
    int len;
    logic [7:0] code;
    kind = $urandom_range(99);
    if ($urandom_range(1) == 1) add_request(REQ_SENT, 8'($urandom));
    frame_body.delete();
    frame_body.push_back(8'($urandom));
    if (kind < 35) begin
      // good register read
      nb = $urandom_range(16);
      frame_body.push_back(FUNC_READ_HOLD);
      frame_body.push_back(8'(nb));
      add_random_bytes(nb);
      send_frame(1'b0);
    end else if (kind < 48) begin
      // good single write echo
      frame_body.push_back(FUNC_WRITE_SINGLE);
      add_random_bytes(4);
      send_frame(1'b0);
    end else if (kind < 54) begin
      // exception response
      frame_body.push_back(8'($urandom) | FUNC_EXC_MASK);
      add_random_bytes(1);
      send_frame(1'b0);
    end else if (kind < 60) begin
      // function code with no extra checks
      do code = 8'($urandom_range(127));
      while (code == FUNC_READ_HOLD || code == FUNC_WRITE_SINGLE);
      frame_body.push_back(code);
      add_random_bytes($urandom_range(6));
      send_frame(1'b0);
    end else if (kind < 66) begin
      // register count above the table size
      frame_body.push_back(FUNC_READ_HOLD);
      frame_body.push_back(8'($urandom_range(2 * REG_COUNT + 2, 255)));
      add_random_bytes($urandom_range(4));
      send_frame(1'b0);
    end else if (kind < 72) begin
      // read whose length disagrees with its byte count
      nb = $urandom_range(16);
      do len = $urandom_range(20);
      while (len == nb);
      frame_body.push_back(FUNC_READ_HOLD);
      frame_body.push_back(8'(nb));
      add_random_bytes(len);
      send_frame(1'b0);
    end else if (kind < 77) begin
      // write echo of the wrong length
      do len = $urandom_range(8);
      while (len == 4);
      frame_body.push_back(FUNC_WRITE_SINGLE);
      add_random_bytes(len);
      send_frame(1'b0);
    end else if (kind < 85) begin
      // crc error on an otherwise good frame
      if ($urandom_range(1) == 1) begin
        nb = $urandom_range(16);
        frame_body.push_back(FUNC_READ_HOLD);
        frame_body.push_back(8'(nb));
        add_random_bytes(nb);
      end else begin
        frame_body.push_back(FUNC_WRITE_SINGLE);
        add_random_bytes(4);
      end
      send_frame(1'b1);
    end else if (kind < 91) begin
      // short frame, with or without a valid crc
      if ($urandom_range(1) == 1) begin
        send_frame(1'b0);
      end else begin
        len = $urandom_range(3);
        for (int i = 0; i < len; i++) add_request(REQ_BYTE, 8'($urandom));
        add_request(REQ_IDLE, 8'($urandom));
      end
    end else if (kind < 95) begin
      add_request(REQ_SENT, 8'($urandom));
    end else begin
      // garbage with unused and request-sent events mixed in
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0: add_request(REQ_UNUSED, 8'($urandom));
          1: add_request(REQ_SENT, 8'($urandom));
          default: add_request(REQ_BYTE, 8'($urandom));
        endcase
      end
      add_request(REQ_IDLE, 8'($urandom));
    end
  endtask

  // reset, stimulus and end of run
  initial begin
    int target;
    rx_crc = CRC_INIT;
    rx_count = '0;
    foreach (rx_store[i]) rx_store[i] = 8'h00;
    foreach (holding_regs[i]) holding_regs[i] = 16'h0000;
    ready_bit = 1'b1;
    error_bit = 1'b0;

    // directed: request sent, empty frame, unused request
    add_request(REQ_SENT, 8'h00);
    add_request(REQ_IDLE, 8'hFF);
    add_request(REQ_UNUSED, 8'hFF);
    // read of two registers holding the extreme values
    frame_body = '{8'h00, FUNC_READ_HOLD, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame(1'b0);
    // exception response
    frame_body = '{8'hFF, FUNC_READ_HOLD | FUNC_EXC_MASK, 8'h02};
    send_frame(1'b0);
    // shortest frame that passes, plain function code
    frame_body = '{8'h11, FUNC_OTHER};
    send_frame(1'b0);

    // random phases; each starts once the receiver has caught up
    for (int p = 0; p < 4; p++) begin
      build_phase = p;
      build_drain = 1'b1;
      if (p == 0) begin
        // overlong frame, byte count runs into saturation
        send_long_frame(FRAME_MAX + 1);
      end
      target = counted_items + PHASE_ITEMS;
      while (counted_items < target) random_frame();
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("covered %0d requests in %0d frames under four idle and stall mixes",
             requests_accepted, frames_sent);
    $display("checked %0d results, %0d of them register updates",
             results_checked, register_results);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timeout: receiver stopped making progress");
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
